[design/tgw_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and codes for the turmite grid walker.
// No dependencies; imported by the walker top level.
package tgw_pkg;

  // Grid size
  localparam int GRID_W = 512;
  localparam int GRID_H = 512;
  localparam int X_W    = $clog2(GRID_W);
  localparam int Y_W    = $clog2(GRID_H);

  // Field widths of the words on the ports
  localparam int COORD_W = 9;
  localparam int ACT_W   = 2;
  localparam int DIR_W   = 2;
  localparam int GEN_W   = 32;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_STEP  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Heading codes
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

endpackage

[design/tgw_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/turmite_grid_walker.sv]
`timescale 1ns / 1ps
// Langton's ant on a toroidal one-bit grid held in a row-wide memory (one row per word).
// After reset the block clears the grid one row per cycle, all GRID_H rows (512), with
// in_stall high; the configuration port is open throughout. The row under the ant (or
// the addressed row) is read in the accept cycle and modified and written back in ST_EXEC
// once the output register is free; no new word is taken before then. A finished result
// waits in the output register; the next word is taken meanwhile.
// Depends on tgw_pkg and tgw_ram.
module turmite_grid_walker (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_mirror_mode,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tgw_pkg::ACT_W-1:0]    in_action,
  input  logic [tgw_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [tgw_pkg::COORD_W-1:0]  in_cell_y,
  input  logic                         in_cell_value,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tgw_pkg::COORD_W-1:0]  out_ant_x,
  output logic [tgw_pkg::COORD_W-1:0]  out_ant_y,
  output logic [tgw_pkg::COORD_W-1:0]  out_prev_x,
  output logic [tgw_pkg::COORD_W-1:0]  out_prev_y,
  output logic [tgw_pkg::DIR_W-1:0]    out_ant_dir,
  output logic                         out_cell_out,
  output logic [tgw_pkg::GEN_W-1:0]    out_generation
);
  import tgw_pkg::*;

  state_t           state_r, state_nxt;
  logic [Y_W-1:0]   clr_cnt_r;
  logic             mirror_r;

  logic [X_W-1:0]   pos_x_r, pos_x_nxt;
  logic [Y_W-1:0]   pos_y_r, pos_y_nxt;
  logic [X_W-1:0]   last_x_r;
  logic [Y_W-1:0]   last_y_r;
  logic [DIR_W-1:0] dir_r, dir_nxt;
  logic [GEN_W-1:0] gen_r;

  // latched word
  logic [ACT_W-1:0] act_r;
  logic [X_W-1:0]   cx_r;
  logic [Y_W-1:0]   cy_r;
  logic             cv_r;
  logic             in_rng_r;

  logic             out_valid_r;
  logic             out_free;
  logic             in_acc;
  logic             finish;

  // memory ports
  logic             ram_we, ram_re;
  logic [Y_W-1:0]   ram_waddr, ram_raddr;
  logic [GRID_W-1:0] ram_wdata, ram_rdata, row_mod;
  logic             cell_res, old_bit, row_we;
  logic [X_W-1:0]   bit_idx;
  logic             bit_val;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign finish    = (state_r == ST_EXEC) && out_free;
  assign cfg_ready = (state_r != ST_EXEC);
  assign old_bit   = ram_rdata[pos_x_r];

  tgw_ram #(
    .WIDTH (GRID_W),
    .DEPTH (GRID_H)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read the row under the ant or the addressed row on accept
  assign ram_re    = in_acc;
  assign ram_raddr = (in_action == ACT_STEP) ? pos_y_r : Y_W'(in_cell_y);

  // pick the bit to change and the word's cell result
  always_comb begin
    bit_idx  = pos_x_r;
    bit_val  = 1'b0;
    row_we   = 1'b0;
    cell_res = 1'b0;
    unique case (act_r)
      ACT_STEP: begin
        bit_idx  = pos_x_r;
        bit_val  = !old_bit;
        row_we   = 1'b1;
        cell_res = !old_bit;
      end
      ACT_WRITE: begin
        bit_idx  = cx_r;
        bit_val  = cv_r;
        row_we   = in_rng_r;
        cell_res = in_rng_r && cv_r;
      end
      ACT_READ: begin
        cell_res = in_rng_r && ram_rdata[cx_r];
      end
      default: begin
        cell_res = 1'b0;
      end
    endcase
  end

  // merge the bit into the row
  always_comb begin
    row_mod          = ram_rdata;
    row_mod[bit_idx] = bit_val;
  end

  // write back the row, or zero rows during the clearing pass
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = finish && row_we;
      ram_waddr = (act_r == ACT_STEP) ? pos_y_r : cy_r;
      ram_wdata = row_mod;
    end
  end

  // turn, mirror and move the ant
  always_comb begin
    dir_nxt   = old_bit ? (dir_r + 2'd1) : (dir_r - 2'd1);
    if (mirror_r) begin
      dir_nxt = dir_nxt + 2'd2;
    end
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    unique case (dir_nxt)
      DIR_UP: begin
        pos_y_nxt = (pos_y_r == '0) ? Y_W'(GRID_H - 1) : pos_y_r - 1'b1;
      end
      DIR_RIGHT: begin
        pos_x_nxt = (pos_x_r == X_W'(GRID_W - 1)) ? '0 : pos_x_r + 1'b1;
      end
      DIR_DOWN: begin
        pos_y_nxt = (pos_y_r == Y_W'(GRID_H - 1)) ? '0 : pos_y_r + 1'b1;
      end
      DIR_LEFT: begin
        pos_x_nxt = (pos_x_r == '0) ? X_W'(GRID_W - 1) : pos_x_r - 1'b1;
      end
      default: begin
        pos_x_nxt = pos_x_r;
      end
    endcase
  end

  // next controller state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == Y_W'(GRID_H - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control and ant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mirror_r    <= 1'b1;
      pos_x_r     <= X_W'(GRID_W / 2);
      pos_y_r     <= Y_W'(GRID_H / 2);
      last_x_r    <= X_W'(GRID_W / 2);
      last_y_r    <= Y_W'(GRID_H / 2);
      dir_r       <= DIR_UP;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        mirror_r <= cfg_mirror_mode;
      end
      if (finish && (act_r == ACT_STEP)) begin
        last_x_r <= pos_x_r;
        last_y_r <= pos_y_r;
        pos_x_r  <= pos_x_nxt;
        pos_y_r  <= pos_y_nxt;
        dir_r    <= dir_nxt;
        gen_r    <= gen_r + 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_action;
      cx_r     <= X_W'(in_cell_x);
      cy_r     <= Y_W'(in_cell_y);
      cv_r     <= in_cell_value;
      in_rng_r <= (32'(in_cell_x) < GRID_W) && (32'(in_cell_y) < GRID_H);
    end
  end

  // load the result word
  always_ff @(posedge clk) begin
    if (finish) begin
      out_cell_out <= cell_res;
      if (act_r == ACT_STEP) begin
        out_ant_x      <= COORD_W'(pos_x_nxt);
        out_ant_y      <= COORD_W'(pos_y_nxt);
        out_prev_x     <= COORD_W'(pos_x_r);
        out_prev_y     <= COORD_W'(pos_y_r);
        out_ant_dir    <= dir_nxt;
        out_generation <= gen_r + 1'b1;
      end else begin
        out_ant_x      <= COORD_W'(pos_x_r);
        out_ant_y      <= COORD_W'(pos_y_r);
        out_prev_x     <= COORD_W'(last_x_r);
        out_prev_y     <= COORD_W'(last_y_r);
        out_ant_dir    <= dir_r;
        out_generation <= gen_r;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

[tb/turmite_grid_walker_tb.sv]
`timescale 1ns / 1ps
// Testbench for turmite_grid_walker: directed and random step, write, read and unused words
// with random gaps and stalls, each result word checked against an in-bench walker model.
// Depends on tgw_pkg and the walker RTL; needs no files or arguments.
module turmite_grid_walker_tb;
  import tgw_pkg::*;

  // Action code the block leaves unused
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0] X_LAST = COORD_W'(GRID_W - 1);
  localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(GRID_H - 1);
  localparam logic [COORD_W-1:0] X_MID = COORD_W'(GRID_W / 2);
  localparam logic [COORD_W-1:0] Y_MID = COORD_W'(GRID_H / 2);
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 16;
  // Slowest run: ~1600 words with their gaps and stalls, plus clearing and hold;
  // allow roughly eight times that.
  localparam longint RUN_LIMIT_NS = 20_000_000;

  typedef struct packed {
    logic [COORD_W-1:0] ant_x;
    logic [COORD_W-1:0] ant_y;
    logic [COORD_W-1:0] prev_x;
    logic [COORD_W-1:0] prev_y;
    logic [DIR_W-1:0]   ant_dir;
    logic               cell_val;
    logic [GEN_W-1:0]   generation;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_mirror_mode;
  logic in_valid;
  logic in_stall;
  logic [ACT_W-1:0] in_action;
  logic [COORD_W-1:0] in_cell_x;
  logic [COORD_W-1:0] in_cell_y;
  logic in_cell_value;
  logic out_valid;
  logic out_stall;
  logic [COORD_W-1:0] out_ant_x;
  logic [COORD_W-1:0] out_ant_y;
  logic [COORD_W-1:0] out_prev_x;
  logic [COORD_W-1:0] out_prev_y;
  logic [DIR_W-1:0] out_ant_dir;
  logic out_cell_out;
  logic [GEN_W-1:0] out_generation;

  // Walker model state
  bit [GRID_W-1:0] grid_q [GRID_H];
  logic [COORD_W-1:0] ant_x_q = X_MID;
  logic [COORD_W-1:0] ant_y_q = Y_MID;
  logic [COORD_W-1:0] flip_x_q = X_MID;
  logic [COORD_W-1:0] flip_y_q = Y_MID;
  logic [DIR_W-1:0] heading_q = DIR_UP;
  logic [GEN_W-1:0] gen_q = '0;
  logic mirror_q = 1'b1;

  walk_result_t walk_result_q[$];
  int err_count = 0;
  int words_sent = 0;
  bit gaps_off = 1'b0;
  bit hold_req = 1'b0;

  turmite_grid_walker u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_mirror_mode(cfg_mirror_mode),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ant_x      (out_ant_x),
    .out_ant_y      (out_ant_y),
    .out_prev_x     (out_prev_x),
    .out_prev_y     (out_prev_y),
    .out_ant_dir    (out_ant_dir),
    .out_cell_out   (out_cell_out),
    .out_generation (out_generation)
  );

  always #10 clk = ~clk;

  // Advance the model by one word and return the result it reports
  function automatic walk_result_t predict_walk(input logic [ACT_W-1:0] act,
                                                input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic value);
    walk_result_t r;
    logic was_set;
    logic cell_val;
    cell_val = 1'b0;
    case (act)
      ACT_STEP: begin
        flip_x_q = ant_x_q;
        flip_y_q = ant_y_q;
        was_set = grid_q[ant_y_q][ant_x_q];
        cell_val = ~was_set;
        grid_q[ant_y_q][ant_x_q] = cell_val;
        // right on a set cell, left on a clear one; mirror mode reverses the new heading
        heading_q = was_set ? heading_q + 2'd1 : heading_q - 2'd1;
        if (mirror_q) heading_q = heading_q + 2'd2;
        case (heading_q)
          DIR_UP:    ant_y_q = (ant_y_q == 0) ? Y_LAST : ant_y_q - 1'b1;
          DIR_RIGHT: ant_x_q = (ant_x_q == X_LAST) ? '0 : ant_x_q + 1'b1;
          DIR_DOWN:  ant_y_q = (ant_y_q == Y_LAST) ? '0 : ant_y_q + 1'b1;
          default:   ant_x_q = (ant_x_q == 0) ? X_LAST : ant_x_q - 1'b1;
        endcase
        gen_q = gen_q + 1'b1;
      end
      ACT_WRITE: begin
        if (x < GRID_W && y < GRID_H) begin
          grid_q[y][x] = value;
          cell_val = value;
        end
      end
      ACT_READ: begin
        if (x < GRID_W && y < GRID_H) cell_val = grid_q[y][x];
      end
      default: cell_val = 1'b0;
    endcase
    r.ant_x = ant_x_q;
    r.ant_y = ant_y_q;
    r.prev_x = flip_x_q;
    r.prev_y = flip_y_q;
    r.ant_dir = heading_q;
    r.cell_val = cell_val;
    r.generation = gen_q;
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word, hold it until accepted, then record its expected result
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_cell_x <= x;
    in_cell_y <= y;
    in_cell_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    walk_result_q.push_back(predict_walk(act, x, y, value));
    if (act != ACT_UNUSED) words_sent++;
  endtask

  task automatic step_ant();
    send_word(ACT_STEP, COORD_W'($urandom_range(0, 2**COORD_W - 1)),
              COORD_W'($urandom_range(0, 2**COORD_W - 1)), 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (walk_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_mirror(input logic value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_mirror_mode <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    mirror_q = value;
  endtask

  // Walk a zigzag between two perpendicular headings, setting the cell under the
  // ant beforehand whenever its value would give the wrong turn
  task automatic steer_walk(input logic [DIR_W-1:0] dir_a, input logic [DIR_W-1:0] dir_b,
                            input int steps);
    logic [DIR_W-1:0] target;
    logic [DIR_W-1:0] turn;
    logic [DIR_W-1:0] h_cw;
    logic [DIR_W-1:0] h_ccw;
    logic need;
    for (int i = 0; i < steps; i++) begin
      h_cw = heading_q + 2'd1;
      h_ccw = heading_q - 2'd1;
      if (heading_q == dir_a) target = dir_b;
      else if (heading_q == dir_b) target = dir_a;
      else if (h_cw == dir_a || h_ccw == dir_a) target = dir_a;
      else target = dir_b;
      turn = target - heading_q;
      need = (turn == 2'd1) ^ mirror_q;
      if (grid_q[ant_y_q][ant_x_q] != need) send_word(ACT_WRITE, ant_x_q, ant_y_q, need);
      step_ant();
    end
  endtask

  task automatic test_reset_state();
    // unused code reports the untouched reset state
    send_word(ACT_UNUSED, X_LAST, Y_LAST, 1'b1);
    send_word(ACT_READ, X_MID, Y_MID, 1'b0);
  endtask

  task automatic test_cell_extremes();
    send_word(ACT_WRITE, '0, '0, 1'b1);
    send_word(ACT_WRITE, X_LAST, Y_LAST, 1'b1);
    send_word(ACT_WRITE, X_LAST, '0, 1'b1);
    send_word(ACT_WRITE, '0, Y_LAST, 1'b0);
    send_word(ACT_READ, '0, '0, 1'b0);
    send_word(ACT_READ, X_LAST, Y_LAST, 1'b1);
    send_word(ACT_WRITE, '0, '0, 1'b0);
    send_word(ACT_READ, '0, '0, 1'b1);
    send_word(ACT_UNUSED, '0, '0, 1'b0);
  endtask

  task automatic test_turn_rules();
    // mirror mode on (reset value): clear cell, then a set one
    step_ant();
    send_word(ACT_WRITE, ant_x_q, ant_y_q, 1'b1);
    step_ant();
    step_ant();
    // mirror mode off
    write_mirror(1'b0);
    step_ant();
    send_word(ACT_WRITE, ant_x_q, ant_y_q, 1'b1);
    step_ant();
    step_ant();
    send_word(ACT_READ, flip_x_q, flip_y_q, 1'b0);
  endtask

  task automatic test_stall_pressure();
    wait_idle();
    hold_req = 1'b1;
    gaps_off = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0)
        send_word(ACT_READ, ant_x_q, ant_y_q, 1'($urandom_range(0, 1)));
      else step_ant();
    end
    gaps_off = 1'b0;
  endtask

  task automatic test_edge_wrap();
    // drift up-left across both edges, then back down-right across them again
    write_mirror(1'b0);
    steer_walk(DIR_UP, DIR_LEFT, 270);
    write_mirror(1'b1);
    steer_walk(DIR_LEFT, DIR_UP, 270);
    steer_walk(DIR_DOWN, DIR_RIGHT, 40);
  endtask

  task automatic test_random_mix();
    int words_goal;
    int kind;
    logic mirror_pick;
    logic [DIR_W-1:0] dir_a;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    for (int phase = 0; phase < 4; phase++) begin
      mirror_pick = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_mirror(mirror_pick);
      words_goal = words_sent + 150;
      while (words_sent < words_goal) begin
        gaps_off = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          // free run over the ant's own trail
          repeat ($urandom_range(4, 40)) step_ant();
        end else if (kind < 55) begin
          dir_a = DIR_W'($urandom_range(0, 3));
          steer_walk(dir_a, dir_a + ($urandom_range(0, 1) ? 2'd1 : 2'd3),
                     $urandom_range(4, 24));
        end else if (kind < 75) begin
          // probe cells around the ant
          repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 2))
              0: send_word(ACT_READ, flip_x_q, flip_y_q, 1'($urandom_range(0, 1)));
              1: send_word(ACT_READ, ant_x_q, ant_y_q, 1'($urandom_range(0, 1)));
              default: begin
                px = COORD_W'(ant_x_q + $urandom_range(0, 4) - 2);
                py = COORD_W'(ant_y_q + $urandom_range(0, 4) - 2);
                send_word(ACT_READ, px, py, 1'($urandom_range(0, 1)));
              end
            endcase
          end
        end else if (kind < 90) begin
          repeat ($urandom_range(1, 6))
            send_word($urandom_range(0, 1) ? ACT_WRITE : ACT_READ,
                      COORD_W'($urandom_range(0, 2**COORD_W - 1)),
                      COORD_W'($urandom_range(0, 2**COORD_W - 1)),
                      1'($urandom_range(0, 1)));
        end else if (kind < 95) begin
          // disturb the neighborhood, then let the ant react
          repeat ($urandom_range(1, 4)) begin
            px = COORD_W'(ant_x_q + $urandom_range(0, 2) - 1);
            py = COORD_W'(ant_y_q + $urandom_range(0, 2) - 1);
            send_word(ACT_WRITE, px, py, 1'($urandom_range(0, 1)));
          end
          repeat ($urandom_range(1, 8)) step_ant();
        end else begin
          repeat ($urandom_range(1, 3))
            send_word(ACT_UNUSED, COORD_W'($urandom_range(0, 2**COORD_W - 1)),
                      COORD_W'($urandom_range(0, 2**COORD_W - 1)),
                      1'($urandom_range(0, 1)));
        end
      end
    end
    gaps_off = 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_mirror_mode <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_STEP;
    in_cell_x <= '0;
    in_cell_y <= '0;
    in_cell_value <= 1'b0;
    out_stall <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_cell_extremes();
    test_turn_rules();
    test_stall_pressure();
    test_edge_wrap();
    test_random_mix();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result-side stall: regimes of no, light and heavy stalling, plus the long hold-off
  initial begin : result_stall
    int stall_left;
    int regime;
    int regime_left;
    int r;
    stall_left = 0;
    regime = 0;
    regime_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (regime_left == 0) begin
        regime = $urandom_range(0, 2);
        regime_left = $urandom_range(50, 300);
      end else begin
        regime_left--;
      end
      if (stall_left == 0 && regime != 0) begin
        r = $urandom_range(0, 99);
        if (r < ((regime == 1) ? 10 : 35))
          stall_left = (r % 8 == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [GEN_W-1:0] expected,
                                      input logic [GEN_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      err_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    walk_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (walk_result_q.size() == 0) begin
        $error("result word with no expectation pending");
        err_count++;
      end else begin
        exp_r = walk_result_q.pop_front();
        check_field("ant_x", GEN_W'(exp_r.ant_x), GEN_W'(out_ant_x));
        check_field("ant_y", GEN_W'(exp_r.ant_y), GEN_W'(out_ant_y));
        check_field("prev_x", GEN_W'(exp_r.prev_x), GEN_W'(out_prev_x));
        check_field("prev_y", GEN_W'(exp_r.prev_y), GEN_W'(out_prev_y));
        check_field("ant_dir", GEN_W'(exp_r.ant_dir), GEN_W'(out_ant_dir));
        check_field("cell_out", GEN_W'(exp_r.cell_val), GEN_W'(out_cell_out));
        check_field("generation", exp_r.generation, out_generation);
      end
    end
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
